// File: src/ess_pkg.sv
// Shared types and constants for the elevator stop scheduler.
package ess_pkg;

   localparam int FLOOR_W        = 5;
   localparam int DWELL_W        = 8;
   localparam int NUM_FLOORS_DEF = 32;
   localparam int REQ_DATA_W     = 8;
   localparam int RSP_DATA_W     = 16;
   localparam int CSR_ADDR_W     = 2;
   localparam int CSR_DATA_W     = 8;

   localparam logic [FLOOR_W-1:0] MIN_FLOOR_RST   = 5'd0;
   localparam logic [FLOOR_W-1:0] MAX_FLOOR_RST   = 5'd31;
   localparam logic [DWELL_W-1:0] DWELL_TICKS_RST = 8'd1;

   typedef enum logic [1:0] {
      MODE_TICK = 2'd0,
      MODE_HALL = 2'd1,
      MODE_CAR  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      MOT_IDLE = 2'd0,
      MOT_UP   = 2'd1,
      MOT_DOWN = 2'd2
   } motion_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_MIN_FLOOR   = 2'd0,
      CSR_MAX_FLOOR   = 2'd1,
      CSR_DWELL_TICKS = 2'd2
   } csr_index_type;

endpackage

// File: src/elevator_stop_scheduler.sv
// Elevator stop scheduler: a single-car controller driven by ticks and calls.
//
// The req channel carries one event per transaction: req_tuser holds the kind
// (tick, hall call or car call) and req_tdata the requested floor. Every
// accepted transaction produces exactly one rsp transaction with the car
// floor, door, motion and status flags after that event.
// The csr channel writes the floor limits and the door dwell; it is always
// ready and should only be used while no event is in flight.
// The response is registered at the edge that accepts the event. Throughput is
// one event per cycle while rsp_tready stays high; the state registers and the
// single response register are the only storage, and the next state comes
// from two priority encoders over the stop maps and one floor step.
// When the receiver stalls, the response register holds its transaction and
// req_tready drops until it is taken; a new event is accepted in the same
// cycle that the held response leaves.
// Reset clears both stop maps, parks the car idle at floor 0 with the door
// closed, and restores the limits to 0 and 31 and the dwell to 1 tick.
module elevator_stop_scheduler #(
   parameter int NUM_FLOORS = ess_pkg::NUM_FLOORS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ess_pkg::REQ_DATA_W-1:0]   req_tdata,  // [4:0] floor
   input  logic [1:0]                       req_tuser,  // [1:0] mode
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [4:0] current_floor, [5] door_open, [7:6] motion, [8] arrived,
   // [9] request_queued, [10] all_idle
   output logic [ess_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [ess_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [ess_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ess_pkg::*;

   localparam int IDX_W  = (NUM_FLOORS > 1) ? $clog2(NUM_FLOORS) : 1;
   localparam int DIST_W = (IDX_W > FLOOR_W) ? IDX_W : FLOOR_W;

   logic [FLOOR_W-1:0]    min_floor_ff, max_floor_ff;
   logic [DWELL_W-1:0]    dwell_ticks_ff;
   logic [NUM_FLOORS-1:0] up_ff, up_in, dn_ff, dn_in;
   logic [FLOOR_W-1:0]    car_ff, car_in;
   motion_type            mot_ff, mot_in;
   logic                  door_ff, door_in;
   logic [DWELL_W-1:0]    dwell_ff, dwell_in;
   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                  req_accept;
   mode_type              mode;
   logic [FLOOR_W-1:0]    req_floor;
   logic [DWELL_W-1:0]    dwell_eff;
   logic                  in_range;
   logic [NUM_FLOORS-1:0] call_bit, up_call, dn_call, step_bit, up_clr, dn_clr;
   logic [IDX_W-1:0]      up_lo, dn_hi;
   logic [DIST_W-1:0]     up_pos, dn_pos, car_pos, dist_up, dist_dn;
   motion_type            chosen;
   logic [FLOOR_W-1:0]    step_floor;
   logic                  arrived, queued, all_idle;

   assign req_accept = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign mode      = mode_type'(req_tuser);
   assign req_floor = req_tdata[FLOOR_W-1:0];
   assign dwell_eff = (dwell_ticks_ff == '0) ? DWELL_W'(1) : dwell_ticks_ff;
   assign in_range  = (req_floor >= min_floor_ff) && (req_floor <= max_floor_ff)
                      && (int'(req_floor) < NUM_FLOORS);

   // One-hot masks for the called floor and for the floor after a step.
   always_comb begin
      for (int i = 0; i < NUM_FLOORS; i++) begin
         call_bit[i] = (int'(req_floor) == i);
         step_bit[i] = (int'(step_floor) == i);
      end
   end

   assign up_call = (req_floor > car_ff) ? (up_ff | call_bit) : up_ff;
   assign dn_call = (req_floor < car_ff) ? (dn_ff | call_bit) : dn_ff;

   // Lowest pending up stop and highest pending down stop.
   always_comb begin
      up_lo = '0;
      for (int i = NUM_FLOORS - 1; i >= 0; i--) begin
         if (up_call[i]) begin
            up_lo = IDX_W'(i);
         end
      end
   end

   always_comb begin
      dn_hi = '0;
      for (int i = 0; i < NUM_FLOORS; i++) begin
         if (dn_call[i]) begin
            dn_hi = IDX_W'(i);
         end
      end
   end

   assign up_pos  = DIST_W'(up_lo);
   assign dn_pos  = DIST_W'(dn_hi);
   assign car_pos = DIST_W'(car_ff);
   assign dist_up = (up_pos > car_pos) ? (up_pos - car_pos) : (car_pos - up_pos);
   assign dist_dn = (dn_pos > car_pos) ? (dn_pos - car_pos) : (car_pos - dn_pos);

   always_comb begin
      if ((up_call == '0) && (dn_call == '0)) begin
         chosen = MOT_IDLE;
      end else if (dn_call == '0) begin
         chosen = MOT_UP;
      end else if (up_call == '0) begin
         chosen = MOT_DOWN;
      end else begin
         chosen = (dist_up <= dist_dn) ? MOT_UP : MOT_DOWN;
      end
   end

   // A moving car steps one floor unless it is held at a limit.
   always_comb begin
      step_floor = car_ff;
      if (mot_ff == MOT_UP) begin
         if ((car_ff < max_floor_ff) && ((int'(car_ff) + 1) < NUM_FLOORS)) begin
            step_floor = car_ff + FLOOR_W'(1);
         end
      end else if (mot_ff == MOT_DOWN) begin
         if (car_ff > min_floor_ff) begin
            step_floor = car_ff - FLOOR_W'(1);
         end
      end
   end

   assign up_clr = up_ff & ~step_bit;
   assign dn_clr = dn_ff & ~step_bit;

   always_comb begin
      up_in    = up_ff;
      dn_in    = dn_ff;
      car_in   = car_ff;
      mot_in   = mot_ff;
      door_in  = door_ff;
      dwell_in = dwell_ff;
      arrived  = 1'b0;
      queued   = 1'b0;
      case (mode)
         MODE_HALL, MODE_CAR: begin
            if (in_range) begin
               queued = 1'b1;
               if (req_floor == car_ff) begin
                  door_in  = 1'b1;
                  dwell_in = dwell_eff;
               end else begin
                  up_in = up_call;
                  dn_in = dn_call;
                  if (mot_ff == MOT_IDLE) begin
                     mot_in = chosen;
                  end
               end
            end
         end
         MODE_TICK: begin
            if (door_ff && (dwell_ff != '0)) begin
               dwell_in = dwell_ff - DWELL_W'(1);
               if (dwell_ff == DWELL_W'(1)) begin
                  door_in = 1'b0;
               end
            end
            if (mot_ff == MOT_UP) begin
               car_in  = step_floor;
               arrived = 1'b1;
               if ((up_ff & step_bit) != '0) begin
                  up_in    = up_clr;
                  door_in  = 1'b1;
                  dwell_in = dwell_eff;
                  if ((up_clr == '0) && (dn_ff == '0)) begin
                     mot_in = MOT_IDLE;
                  end else if (up_clr == '0) begin
                     mot_in = MOT_DOWN;
                  end
               end
            end else if (mot_ff == MOT_DOWN) begin
               car_in  = step_floor;
               arrived = 1'b1;
               if ((dn_ff & step_bit) != '0) begin
                  dn_in    = dn_clr;
                  door_in  = 1'b1;
                  dwell_in = dwell_eff;
                  if ((dn_clr == '0) && (up_ff == '0)) begin
                     mot_in = MOT_IDLE;
                  end else if (dn_clr == '0) begin
                     mot_in = MOT_UP;
                  end
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign all_idle    = (mot_in == MOT_IDLE) && (up_in == '0) && (dn_in == '0);
   assign rsp_data_in = RSP_DATA_W'({all_idle, queued, arrived, mot_in, door_in, car_in});

   always_ff @(posedge clock) begin
      if (reset) begin
         min_floor_ff   <= MIN_FLOOR_RST;
         max_floor_ff   <= MAX_FLOOR_RST;
         dwell_ticks_ff <= DWELL_TICKS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_addr))
            CSR_MIN_FLOOR:   min_floor_ff   <= csr_wdata[FLOOR_W-1:0];
            CSR_MAX_FLOOR:   max_floor_ff   <= csr_wdata[FLOOR_W-1:0];
            CSR_DWELL_TICKS: dwell_ticks_ff <= csr_wdata[DWELL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         up_ff    <= '0;
         dn_ff    <= '0;
         car_ff   <= '0;
         mot_ff   <= MOT_IDLE;
         door_ff  <= 1'b0;
         dwell_ff <= '0;
      end else if (req_accept) begin
         up_ff    <= up_in;
         dn_ff    <= dn_in;
         car_ff   <= car_in;
         mot_ff   <= mot_in;
         door_ff  <= door_in;
         dwell_ff <= dwell_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // An open door always has dwell ticks left to count.
   a_door_dwell: assert property (@(posedge clock) disable iff (reset)
      door_ff |-> (dwell_ff != '0))
      else $error("door open with no dwell left");

   // An idle car has no pending stops.
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      (mot_ff == MOT_IDLE) |-> ((up_ff == '0) && (dn_ff == '0)))
      else $error("car idle while stops are pending");

   // Every accepted event leaves a response waiting in the next cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted event produced no response");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the elevator stop scheduler with its own car model.
module tb_top;
   import ess_pkg::*;

   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int HOLD_CYCLES = 300;

   typedef struct packed {
      logic [1:0]         mode;
      logic [FLOOR_W-1:0] floor;
   } lift_event_type;

   typedef struct packed {
      logic [FLOOR_W-1:0] floor_pos;
      logic               door;
      logic [1:0]         motion;
      logic               arrived;
      logic               queued;
      logic               idle_all;
   } car_status_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Car model state and its copy of the limit and dwell registers.
   logic [31:0]        up_map, down_map;
   logic [FLOOR_W-1:0] car_pos;
   motion_type         car_dir;
   logic               door_is_open;
   logic [DWELL_W-1:0] dwell_cnt;
   logic [FLOOR_W-1:0] lim_lo, lim_hi;
   logic [DWELL_W-1:0] dwell_cfg;

   lift_event_type pending_events_q[$];
   car_status_type expected_status_q[$];
   logic        req_taken = 1'b0;
   int          send_idle_pct = 0;
   int          rsp_stall_pct = 0;
   int          holds_requested = 0;
   int          holds_done = 0;
   int          hold_left = 0;
   int          queued_count = 0;
   int          checked_count = 0;
   int          error_count = 0;
   int          tick_count = 0;
   int          call_count = 0;
   int          ignored_count = 0;
   int          arrival_count = 0;

   elevator_stop_scheduler i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic void open_door();
      door_is_open = 1'b1;
      dwell_cnt = (dwell_cfg == '0) ? DWELL_W'(1) : dwell_cfg;
   endfunction

   function automatic car_status_type advance_car(logic [1:0] mode, logic [FLOOR_W-1:0] fl);
      car_status_type r;
      int lo_up, hi_dn, dist_up, dist_dn;
      r.arrived = 1'b0;
      r.queued = 1'b0;
      if (mode == MODE_HALL || mode == MODE_CAR) begin
         if (fl >= lim_lo && fl <= lim_hi) begin
            r.queued = 1'b1;
            if (fl == car_pos) begin
               open_door();
            end else begin
               if (fl > car_pos) up_map[fl] = 1'b1;
               else down_map[fl] = 1'b1;
               // An idle car heads for the nearer of the two candidate stops.
               if (car_dir == MOT_IDLE) begin
                  if (down_map == '0) begin
                     car_dir = MOT_UP;
                  end else if (up_map == '0) begin
                     car_dir = MOT_DOWN;
                  end else begin
                     lo_up = 0;
                     hi_dn = 0;
                     for (int i = 31; i >= 0; i--) if (up_map[i]) lo_up = i;
                     for (int i = 0; i < 32; i++) if (down_map[i]) hi_dn = i;
                     dist_up = (lo_up > car_pos) ? lo_up - car_pos : car_pos - lo_up;
                     dist_dn = (hi_dn > car_pos) ? hi_dn - car_pos : car_pos - hi_dn;
                     car_dir = (dist_up <= dist_dn) ? MOT_UP : MOT_DOWN;
                  end
               end
            end
         end
      end else if (mode == MODE_TICK) begin
         if (door_is_open && dwell_cnt != '0) begin
            dwell_cnt--;
            if (dwell_cnt == '0) door_is_open = 1'b0;
         end
         if (car_dir == MOT_UP) begin
            if (car_pos < lim_hi && car_pos != 5'd31) car_pos++;
            r.arrived = 1'b1;
            if (up_map[car_pos]) begin
               up_map[car_pos] = 1'b0;
               open_door();
               if (up_map == '0 && down_map == '0) car_dir = MOT_IDLE;
               else if (up_map == '0) car_dir = MOT_DOWN;
            end
         end else if (car_dir == MOT_DOWN) begin
            if (car_pos > lim_lo) car_pos--;
            r.arrived = 1'b1;
            if (down_map[car_pos]) begin
               down_map[car_pos] = 1'b0;
               open_door();
               if (up_map == '0 && down_map == '0) car_dir = MOT_IDLE;
               else if (down_map == '0) car_dir = MOT_UP;
            end
         end
      end
      r.floor_pos = car_pos;
      r.door = door_is_open;
      r.motion = car_dir;
      r.idle_all = (car_dir == MOT_IDLE && up_map == '0 && down_map == '0);
      return r;
   endfunction

   function automatic void compare_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endfunction

   // Request driver: a new transaction is offered only once the previous one was taken.
   always @(negedge clock) begin : drive_req
      lift_event_type item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_events_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            item = pending_events_q.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= item.mode;
            req_tdata <= {{(REQ_DATA_W-FLOOR_W){1'b0}}, item.floor};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response receiver with random stalls and a long hold-off whenever one is requested.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_done != holds_requested) begin
         hold_left <= HOLD_CYCLES;
         holds_done <= holds_done + 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin : watch
      car_status_type want, got;
      req_taken <= req_tvalid && req_tready && !reset;
      if (reset) begin
         up_map = '0;
         down_map = '0;
         car_pos = '0;
         car_dir = MOT_IDLE;
         door_is_open = 1'b0;
         dwell_cnt = '0;
         lim_lo = MIN_FLOOR_RST;
         lim_hi = MAX_FLOOR_RST;
         dwell_cfg = DWELL_TICKS_RST;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_addr)
               CSR_MIN_FLOOR:   lim_lo = csr_wdata[FLOOR_W-1:0];
               CSR_MAX_FLOOR:   lim_hi = csr_wdata[FLOOR_W-1:0];
               CSR_DWELL_TICKS: dwell_cfg = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            want = advance_car(req_tuser, req_tdata[FLOOR_W-1:0]);
            expected_status_q.push_back(want);
            if (req_tuser == MODE_TICK) tick_count++;
            if (want.queued) call_count++;
            else if (req_tuser != MODE_TICK) ignored_count++;
            if (want.arrived) arrival_count++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.floor_pos = rsp_tdata[4:0];
            got.door = rsp_tdata[5];
            got.motion = rsp_tdata[7:6];
            got.arrived = rsp_tdata[8];
            got.queued = rsp_tdata[9];
            got.idle_all = rsp_tdata[10];
            if (expected_status_q.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, got 0x%h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = expected_status_q.pop_front();
               compare_field("current_floor", want.floor_pos, got.floor_pos);
               compare_field("door_open", want.door, got.door);
               compare_field("motion", want.motion, got.motion);
               compare_field("arrived", want.arrived, got.arrived);
               compare_field("request_queued", want.queued, got.queued);
               compare_field("all_idle", want.idle_all, got.idle_all);
               checked_count++;
            end
         end
      end
   end

   function automatic void push_item(logic [1:0] mode, logic [FLOOR_W-1:0] fl);
      lift_event_type item;
      item.mode = mode;
      item.floor = fl;
      pending_events_q.push_back(item);
      queued_count++;
   endfunction

   task automatic wait_until_drained();
      while (pending_events_q.size() != 0 || checked_count != queued_count)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Bursts of calls followed by runs of ticks let the car actually serve its stops;
   // out-of-range floors and the unused mode are mixed in as noise.
   task automatic queue_random_traffic(int count, logic [FLOOR_W-1:0] lo,
                                       logic [FLOOR_W-1:0] hi);
      int made, ticks;
      logic [1:0] call_mode;
      logic [FLOOR_W-1:0] fl;
      made = 0;
      while (made < count) begin
         repeat ($urandom_range(4, 1)) begin
            call_mode = $urandom_range(1, 0) ? MODE_HALL : MODE_CAR;
            fl = FLOOR_W'($urandom_range(31, 0));
            case ($urandom_range(9, 0))
               7: begin
                  push_item(call_mode, fl);
                  made++;
               end
               8: push_item(MODE_UNUSED, fl);
               9: begin
                  push_item(MODE_TICK, fl);
                  made++;
               end
               default: begin
                  if (lo <= hi) fl = FLOOR_W'($urandom_range(hi, lo));
                  push_item(call_mode, fl);
                  made++;
               end
            endcase
         end
         ticks = ($urandom_range(9, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(20, 1);
         repeat (ticks) begin
            push_item(MODE_TICK, FLOOR_W'($urandom_range(31, 0)));
            made++;
         end
      end
   endtask

   task automatic run_phase(logic [FLOOR_W-1:0] lo, logic [FLOOR_W-1:0] hi,
                            logic [DWELL_W-1:0] dwell, int idle_pct, int stall_pct,
                            int count);
      wait_until_drained();
      write_reg(CSR_MIN_FLOOR, CSR_DATA_W'(lo));
      write_reg(CSR_MAX_FLOOR, CSR_DATA_W'(hi));
      write_reg(CSR_DWELL_TICKS, dwell);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      queue_random_traffic(count, lo, hi);
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Default limits: door at the current floor, service up then back down to 0.
      push_item(MODE_TICK, 5'd0);
      push_item(MODE_UNUSED, 5'd31);
      push_item(MODE_CAR, 5'd0);
      push_item(MODE_TICK, 5'd31);
      push_item(MODE_HALL, 5'd3);
      push_item(MODE_CAR, 5'd1);
      push_item(MODE_TICK, 5'd0);
      push_item(MODE_HALL, 5'd0);
      push_item(MODE_TICK, 5'd0);
      push_item(MODE_TICK, 5'd0);
      push_item(MODE_TICK, 5'd0);
      push_item(MODE_TICK, 5'd0);
      push_item(MODE_TICK, 5'd0);
      push_item(MODE_HALL, 5'd31);
      push_item(MODE_TICK, 5'd0);

      // Narrow the limits under a car that still heads for floor 31, with zero dwell.
      wait_until_drained();
      write_reg(CSR_MIN_FLOOR, 8'd2);
      write_reg(CSR_MAX_FLOOR, 8'd6);
      write_reg(CSR_DWELL_TICKS, 8'd0);
      push_item(MODE_TICK, 5'd0);
      push_item(MODE_CAR, 5'd1);
      push_item(MODE_CAR, 5'd7);
      push_item(MODE_CAR, 5'd2);
      repeat (5) push_item(MODE_TICK, 5'd0);
      push_item(MODE_HALL, 5'd4);
      push_item(MODE_TICK, 5'd0);
      push_item(MODE_UNUSED, 5'd0);

      run_phase(5'd0, 5'd31, 8'd1, 0, 0, 250);
      run_phase(5'd3, 5'd20, 8'd3, 51, 0, 250);
      run_phase(5'd10, 5'd10, 8'd255, 0, 51, 150);
      run_phase(5'd31, 5'd0, 8'd0, 32, 32, 150);
      run_phase(5'd0, 5'd31, 8'd2, 0, 0, 250);
      holds_requested++;
      run_phase(5'd5, 5'd27, 8'd8, 32, 32, 250);
      run_phase(5'd0, 5'd31, 8'd1, 0, 0, 125);
      // The sender pauses here until every outstanding result has come back.
      wait_until_drained();
      queue_random_traffic(125, 5'd0, 5'd31);

      wait_until_drained();
      repeat (10) @(negedge clock);
      if (expected_status_q.size() != 0) begin
         $display("%0t ns: %0d expected results never arrived", $time,
                  expected_status_q.size());
         error_count++;
      end
      $display("Run covered %0d ticks, %0d accepted calls and %0d ignored items,",
               tick_count, call_count, ignored_count);
      $display("with %0d arrivals over a range of limit and dwell settings.", arrival_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("%0t ns: timeout, simulation did not complete", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
